// ===== hdl/mcqc_pkg.sv =====
package mcqc_pkg;

  localparam int ENCODERS    = 2;
  localparam int COUNT_WIDTH = 32;

  localparam int ENC_W  = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
  localparam int PIN_W  = 3;
  localparam int IDX_W  = 2;
  localparam int OUT_CW = 32;

  typedef enum logic [1:0] {
    REQ_EDGE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_t;

  // x4 transition table, pair = {B, A}
  function automatic step_t step_dir(input logic [1:0] prev, input logic [1:0] next);
    step_t s;
    case ({prev, next})
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_UP;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_DOWN;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/mcqc_ifs.sv =====
interface mcqc_req_if
  import mcqc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [PIN_W-1:0] pin_index;
  logic             pin_level;

  modport source (output valid, req_type, pin_index, pin_level, input ready);
  modport sink   (input valid, req_type, pin_index, pin_level, output ready);
endinterface

interface mcqc_cnt_if
  import mcqc_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         encoder_index;
  logic signed [OUT_CW-1:0] count_value;
  logic                     last;

  modport source (output valid, encoder_index, count_value, last, input ready);
  modport sink   (input valid, encoder_index, count_value, last, output ready);
endinterface

// ===== hdl/mcqc_ram.sv =====
module mcqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/multi_channel_quadrature_counter.sv =====
// channel   dir     beat / fields
// req       in      req_type, pin_index, pin_level (edge, read all, clear all)
// rsp       out     encoder_index, count_value, last (one beat per encoder on read)
// cfg       in      cfg_wr_en, cfg_wr_data (enable)
//
// Edge and clear beats are taken every cycle while no read sequence runs;
// an edge is a read-modify-write on the count RAM, forwarded from the
// previous write. A read beat holds req.ready low while the sequencer walks
// the RAM read port, one encoder per cycle unless rsp stalls fill the
// 2-entry output queue.
// rst is synchronous; counts read as zero until written, via per-encoder
// valid flops, so no clearing pass is needed. Clear drops all valid flops.
module multi_channel_quadrature_counter
  import mcqc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  mcqc_req_if.sink     req,
  mcqc_cnt_if.source   rsp
);

  localparam int QDEPTH = 2;

  logic                   enable;
  logic [1:0]             pin_pairs [ENCODERS];
  logic [ENCODERS-1:0]    cnt_vld;

  logic                   seq_busy;
  logic [ENC_W-1:0]       seq_idx;

  logic                   s2_upd;
  logic                   s2_rep;
  logic [ENC_W-1:0]       s2_enc;
  logic                   s2_up;
  logic                   s2_last;

  logic                   wr_q_vld;
  logic [ENC_W-1:0]       wr_q_addr;
  logic [COUNT_WIDTH-1:0] wr_q_data;

  logic [IDX_W-1:0]       q_idx  [QDEPTH];
  logic [OUT_CW-1:0]      q_cnt  [QDEPTH];
  logic                   q_last [QDEPTH];
  logic                   q_head;
  logic [1:0]             q_cnt_n;

  logic                   acc;
  logic                   edge_go;
  logic [ENC_W-1:0]       in_enc;
  logic [1:0]             old_pair;
  logic [1:0]             new_pair;
  step_t                  step;
  logic                   room;
  logic                   issue;
  logic                   seq_end;
  logic [ENC_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   push;
  logic                   pop;
  logic                   q_tail;

  assign acc      = req.valid && req.ready;
  assign req.ready = !seq_busy;
  assign in_enc   = ENC_W'(req.pin_index[PIN_W-1:1]);
  assign old_pair = pin_pairs[in_enc];
  assign new_pair = req.pin_index[0] ? {req.pin_level, old_pair[0]}
                                     : {old_pair[1], req.pin_level};
  assign step     = step_dir(old_pair, new_pair);
  assign edge_go  = acc && (req.req_type == REQ_EDGE) && enable
                    && ({1'b0, req.pin_index} < (PIN_W+1)'(2 * ENCODERS));

  assign pop    = rsp.valid && rsp.ready;
  assign push   = s2_rep;
  assign room   = ({1'b0, q_cnt_n} + 3'(s2_rep) - 3'(pop)) < 3'(QDEPTH);
  assign issue  = seq_busy && room;
  assign seq_end = (seq_idx == ENC_W'(ENCODERS - 1));
  assign rd_addr = seq_busy ? seq_idx : in_enc;

  mcqc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENCODERS)) u_cnt_ram (
    .clk   (clk),
    .we    (s2_upd),
    .waddr (s2_enc),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    if (!cnt_vld[s2_enc]) begin
      base = '0;
    end else if (wr_q_vld && (wr_q_addr == s2_enc)) begin
      base = wr_q_data;
    end else begin
      base = rd_data;
    end
    wr_data = s2_up ? base + COUNT_WIDTH'(1) : base - COUNT_WIDTH'(1);
  end

  assign q_tail            = q_head + q_cnt_n[0];
  assign rsp.valid         = (q_cnt_n != 2'd0);
  assign rsp.encoder_index = q_idx[q_head];
  assign rsp.count_value   = q_cnt[q_head];
  assign rsp.last          = q_last[q_head];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      cnt_vld  <= '0;
      seq_busy <= 1'b0;
      seq_idx  <= '0;
      s2_upd   <= 1'b0;
      s2_rep   <= 1'b0;
      wr_q_vld <= 1'b0;
      q_head   <= 1'b0;
      q_cnt_n  <= 2'd0;
      for (int e = 0; e < ENCODERS; e++) begin
        pin_pairs[e] <= 2'b00;
      end
    end else begin
      if (cfg_wr_en) begin
        enable <= cfg_wr_data;
      end
      if (edge_go) begin
        pin_pairs[in_enc] <= new_pair;
      end
      s2_upd   <= edge_go && (step != STEP_NONE);
      s2_rep   <= issue;
      wr_q_vld <= s2_upd;
      if (acc && (req.req_type == REQ_CLEAR)) begin
        cnt_vld <= '0;
      end else if (s2_upd) begin
        cnt_vld[s2_enc] <= 1'b1;
      end
      if (acc && (req.req_type == REQ_READ)) begin
        seq_busy <= 1'b1;
        seq_idx  <= '0;
      end else if (issue) begin
        if (seq_end) begin
          seq_busy <= 1'b0;
        end else begin
          seq_idx <= seq_idx + ENC_W'(1);
        end
      end
      if (pop) begin
        q_head <= ~q_head;
      end
      q_cnt_n <= q_cnt_n + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    s2_enc    <= issue ? seq_idx : in_enc;
    s2_up     <= (step == STEP_UP);
    s2_last   <= seq_end;
    wr_q_addr <= s2_enc;
    wr_q_data <= wr_data;
    if (push) begin
      q_idx[q_tail]  <= IDX_W'(s2_enc);
      q_cnt[q_tail]  <= OUT_CW'(signed'(base));
      q_last[q_tail] <= s2_last;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt_n <= 2'(QDEPTH))
    else $error("output queue overflow");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(s2_upd && s2_rep))
    else $error("update and report in flight together");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> !req.ready)
    else $error("req taken during read sequence");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (acc && (req.req_type == REQ_CLEAR)) |=> (cnt_vld == '0))
    else $error("clear did not drop count valid flops");

  a_no_edge_when_off: assert property (@(posedge clk) disable iff (rst)
    !enable |=> !s2_upd)
    else $error("count update while disabled");

endmodule
